// File: sv/segment_intersection_2d_core_defines.svh
// ----------------------------------------------------------------------------
// Segment intersection assertion macros
// Shared concurrent assertion forms used by the segment intersection core.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_2D_CORE_DEFINES_SVH
`define SEGMENT_INTERSECTION_2D_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/sic_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, register codes, reset values and stage payload types.
// ----------------------------------------------------------------------------
package sic_pkg;

	localparam int unsigned TFRAC_DEF = 24;
	localparam int unsigned COORD_W   = 32;
	localparam int unsigned DIFF_W    = 33;
	localparam int unsigned PROD_W    = 66;
	localparam int unsigned WIDE_W    = 67;
	localparam int unsigned MAG_W     = 66;
	localparam int unsigned QUO_W     = 62;
	localparam int unsigned T_W       = 63;
	localparam int unsigned CFG_W     = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned STATUS_W  = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS_SNAP   = 2'd0,
		REG_DET_TOL     = 2'd1,
		REG_PARAM_TOL   = 2'd2,
		REG_RESULT_SNAP = 2'd3
	} cfg_reg_t;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_PARALLEL  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ON_BOTH   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EXTENSION = 2'd2;

	localparam logic [15:0] AXIS_SNAP_RST   = 16'd7;
	localparam logic [31:0] DET_TOL_RST     = 32'd42950;
	localparam logic [23:0] PARAM_TOL_RST   = 24'd168;
	localparam logic [15:0] RESULT_SNAP_RST = 16'd1;

	// Endpoints and snapped directions that ride along with the arithmetic.
	typedef struct packed {
		logic signed [COORD_W-1:0] b1_x;
		logic signed [COORD_W-1:0] b1_y;
		logic signed [COORD_W-1:0] b2_x;
		logic signed [COORD_W-1:0] b2_y;
		logic signed [DIFF_W-1:0]  dx1;
		logic signed [DIFF_W-1:0]  dy1;
		logic signed [DIFF_W-1:0]  dx2;
		logic signed [DIFF_W-1:0]  dy2;
	} side_t;

	// Determinant and numerators out of the front end.
	typedef struct packed {
		logic signed [WIDE_W-1:0] det;
		logic signed [WIDE_W-1:0] num1;
		logic signed [WIDE_W-1:0] num2;
		side_t                    side;
	} front_t;

	// Segment parameters out of the divider.
	typedef struct packed {
		logic                  par;
		logic signed [T_W-1:0] t1;
		logic signed [T_W-1:0] t2;
		side_t                 side;
	} param_t;

	// One finished result item.
	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [COORD_W-1:0] cross_x;
		logic signed [COORD_W-1:0] cross_y;
	} result_t;

endpackage

// File: sv/sic_front.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Three stages: direction snap, cross products, determinant and numerators.
// ----------------------------------------------------------------------------
module sic_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 valid_in,
	input  logic signed [sic_pkg::COORD_W-1:0]   b1_x,
	input  logic signed [sic_pkg::COORD_W-1:0]   b1_y,
	input  logic signed [sic_pkg::COORD_W-1:0]   e1_x,
	input  logic signed [sic_pkg::COORD_W-1:0]   e1_y,
	input  logic signed [sic_pkg::COORD_W-1:0]   b2_x,
	input  logic signed [sic_pkg::COORD_W-1:0]   b2_y,
	input  logic signed [sic_pkg::COORD_W-1:0]   e2_x,
	input  logic signed [sic_pkg::COORD_W-1:0]   e2_y,
	input  logic [15:0]                          axis_snap_tol,
	output logic                                 valid_s3,
	output sic_pkg::front_t                      front_s3
);
	import sic_pkg::*;

	// A direction component below the tolerance in magnitude becomes zero.
	function automatic logic signed [DIFF_W-1:0] snap_dir(
		input logic signed [DIFF_W-1:0] d,
		input logic [15:0]              tol
	);
		logic [DIFF_W-1:0] mag;
		mag = d[DIFF_W-1] ? (~d + 1'b1) : d;
		return (mag < {{(DIFF_W-16){1'b0}}, tol}) ? '0 : d;
	endfunction

	logic                     valid_s1, valid_s2;
	side_t                    side_s1, side_s2;
	logic signed [DIFF_W-1:0] wx_s1, wy_s1;
	logic signed [PROD_W-1:0] prod_s2 [6];
	side_t                    side_c;
	logic signed [PROD_W-1:0] prod_c [6];

	// Differences and snapping.
	always_comb begin
		side_c.b1_x = b1_x;
		side_c.b1_y = b1_y;
		side_c.b2_x = b2_x;
		side_c.b2_y = b2_y;
		side_c.dx1  = snap_dir({e1_x[COORD_W-1], e1_x} - {b1_x[COORD_W-1], b1_x}, axis_snap_tol);
		side_c.dy1  = snap_dir({e1_y[COORD_W-1], e1_y} - {b1_y[COORD_W-1], b1_y}, axis_snap_tol);
		side_c.dx2  = snap_dir({e2_x[COORD_W-1], e2_x} - {b2_x[COORD_W-1], b2_x}, axis_snap_tol);
		side_c.dy2  = snap_dir({e2_y[COORD_W-1], e2_y} - {b2_y[COORD_W-1], b2_y}, axis_snap_tol);
	end

	// The six cross products, one multiplier each.
	always_comb begin
		prod_c[0] = $signed(side_s1.dx2) * $signed(side_s1.dy1);
		prod_c[1] = $signed(side_s1.dy2) * $signed(side_s1.dx1);
		prod_c[2] = $signed(side_s1.dy2) * $signed(wx_s1);
		prod_c[3] = $signed(side_s1.dx2) * $signed(wy_s1);
		prod_c[4] = $signed(side_s1.dy1) * $signed(wx_s1);
		prod_c[5] = $signed(side_s1.dx1) * $signed(wy_s1);
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			wx_s1   <= {b1_x[COORD_W-1], b1_x} - {b2_x[COORD_W-1], b2_x};
			wy_s1   <= {b1_y[COORD_W-1], b1_y} - {b2_y[COORD_W-1], b2_y};
			side_s2 <= side_s1;
			prod_s2 <= prod_c;
			front_s3.det  <= {prod_s2[0][PROD_W-1], prod_s2[0]}
				- {prod_s2[1][PROD_W-1], prod_s2[1]};
			front_s3.num1 <= {prod_s2[2][PROD_W-1], prod_s2[2]}
				- {prod_s2[3][PROD_W-1], prod_s2[3]};
			front_s3.num2 <= {prod_s2[4][PROD_W-1], prod_s2[4]}
				- {prod_s2[5][PROD_W-1], prod_s2[5]};
			front_s3.side <= side_s2;
		end
	end

endmodule

// File: sv/sic_div.sv
// ----------------------------------------------------------------------------
// Segment intersection divider
// Pipelined restoring division for both segment parameters, one quotient
// bit per stage, with saturation and sign applied at the end.
// ----------------------------------------------------------------------------
module sic_div #(
	parameter int unsigned TFRAC = sic_pkg::TFRAC_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_in,
	input  sic_pkg::front_t   front_in,
	input  logic [31:0]       det_tol,
	output logic              valid_out,
	output sic_pkg::param_t   param_out
);
	import sic_pkg::*;

	localparam int unsigned NSH_W = MAG_W + TFRAC;
	localparam int unsigned REM_W = MAG_W + 1;

	typedef struct packed {
		logic  par;
		logic  sat1;
		logic  sat2;
		logic  neg1;
		logic  neg2;
		side_t side;
	} dctl_t;

	// Magnitude stage.
	logic              valid_a;
	logic [MAG_W-1:0]  mdet_a, mn1_a, mn2_a;
	logic              neg1_a, neg2_a;
	side_t             side_a;

	// Division stages; index 0 is the setup stage.
	logic              valid_s [QUO_W+1];
	dctl_t             ctl_s   [QUO_W+1];
	logic [MAG_W-1:0]  den_s   [QUO_W+1];
	logic [REM_W-1:0]  rem_s   [2][QUO_W+1];
	logic [QUO_W-1:0]  low_s   [2][QUO_W+1];
	logic [QUO_W-1:0]  quo_s   [2][QUO_W+1];

	logic [NSH_W-1:0]  nsh     [2];
	logic [REM_W-1:0]  rem0    [2];
	logic [REM_W-1:0]  trial   [2][QUO_W];
	logic              fit     [2][QUO_W];
	dctl_t             ctl_c;
	logic [QUO_W-1:0]  tmag    [2];
	logic signed [T_W-1:0] tval [2];

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-1:0] m;
		m = v[WIDE_W-1] ? (~v + 1'b1) : v;
		return m[MAG_W-1:0];
	endfunction

	// Setup: first partial remainder, saturation and parallel checks.
	always_comb begin
		nsh[0] = {mn1_a, {TFRAC{1'b0}}};
		nsh[1] = {mn2_a, {TFRAC{1'b0}}};
		rem0[0] = REM_W'(nsh[0] >> QUO_W);
		rem0[1] = REM_W'(nsh[1] >> QUO_W);
		ctl_c.par  = mdet_a <= {{(MAG_W-32){1'b0}}, det_tol};
		ctl_c.sat1 = rem0[0] >= {1'b0, mdet_a};
		ctl_c.sat2 = rem0[1] >= {1'b0, mdet_a};
		ctl_c.neg1 = neg1_a;
		ctl_c.neg2 = neg2_a;
		ctl_c.side = side_a;
	end

	// One trial subtraction per lane and stage.
	always_comb begin
		for (int k = 0; k < QUO_W; k++) begin
			for (int l = 0; l < 2; l++) begin
				trial[l][k] = {rem_s[l][k][REM_W-2:0], low_s[l][k][QUO_W-1]};
				fit[l][k]   = trial[l][k] >= {1'b0, den_s[k]};
			end
		end
	end

	// Saturate the magnitude and apply the sign.
	always_comb begin
		tmag[0] = ctl_s[QUO_W].sat1 ? '1 : quo_s[0][QUO_W];
		tmag[1] = ctl_s[QUO_W].sat2 ? '1 : quo_s[1][QUO_W];
		tval[0] = ctl_s[QUO_W].neg1 ? -$signed({1'b0, tmag[0]}) : $signed({1'b0, tmag[0]});
		tval[1] = ctl_s[QUO_W].neg2 ? -$signed({1'b0, tmag[1]}) : $signed({1'b0, tmag[1]});
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_a   <= 1'b0;
			valid_s   <= '{default: 1'b0};
			valid_out <= 1'b0;
		end else if (en) begin
			valid_a    <= valid_in;
			valid_s[0] <= valid_a;
			for (int k = 0; k < QUO_W; k++) begin
				valid_s[k+1] <= valid_s[k];
			end
			valid_out <= valid_s[QUO_W];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			mdet_a <= mag_of(front_in.det);
			mn1_a  <= mag_of(front_in.num1);
			mn2_a  <= mag_of(front_in.num2);
			neg1_a <= front_in.num1[WIDE_W-1] ^ front_in.det[WIDE_W-1];
			neg2_a <= front_in.num2[WIDE_W-1] ^ front_in.det[WIDE_W-1];
			side_a <= front_in.side;

			ctl_s[0] <= ctl_c;
			den_s[0] <= mdet_a;
			for (int l = 0; l < 2; l++) begin
				rem_s[l][0] <= rem0[l];
				low_s[l][0] <= nsh[l][QUO_W-1:0];
				quo_s[l][0] <= '0;
			end

			for (int k = 0; k < QUO_W; k++) begin
				ctl_s[k+1] <= ctl_s[k];
				den_s[k+1] <= den_s[k];
				for (int l = 0; l < 2; l++) begin
					rem_s[l][k+1] <= fit[l][k] ? (trial[l][k] - {1'b0, den_s[k]}) : trial[l][k];
					low_s[l][k+1] <= {low_s[l][k][QUO_W-2:0], 1'b0};
					quo_s[l][k+1] <= {quo_s[l][k][QUO_W-2:0], fit[l][k]};
				end
			end

			param_out.par  <= ctl_s[QUO_W].par;
			param_out.t1   <= tval[0];
			param_out.t2   <= tval[1];
			param_out.side <= ctl_s[QUO_W].side;
		end
	end

endmodule

// File: sv/sic_back.sv
// ----------------------------------------------------------------------------
// Segment intersection back end
// Range checks, segment choice, crossing reconstruction, saturation, snap.
// ----------------------------------------------------------------------------
module sic_back #(
	parameter int unsigned TFRAC = sic_pkg::TFRAC_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_in,
	input  sic_pkg::param_t   param_in,
	input  logic [23:0]       param_tol,
	input  logic [15:0]       result_snap_tol,
	output logic              valid_out,
	output sic_pkg::result_t  result_out
);
	import sic_pkg::*;

	localparam int unsigned FLG_W = T_W + 3;
	localparam int unsigned MUL_W = DIFF_W + T_W;
	localparam int unsigned SUM_W = MUL_W + 1;

	logic valid_b1, valid_b2, valid_b3, valid_b4, valid_b5;

	// Stage 1: flags.
	logic                  on1_b1, on2_b1, near_b1, par_b1;
	logic signed [T_W-1:0] t1_b1, t2_b1;
	side_t                 side_b1;
	logic signed [FLG_W-1:0] t1e, t2e, slk, one;
	logic                  on1_c, on2_c, near_c;

	// Stage 2: selected operands.
	logic [STATUS_W-1:0]       status_b2;
	logic                      par_b2;
	logic signed [COORD_W-1:0] base_b2 [2];
	logic signed [DIFF_W-1:0]  dir_b2  [2];
	logic signed [T_W-1:0]     t_b2;

	// Stage 3: partial products.
	logic [STATUS_W-1:0]       status_b3, status_b4, status_b5;
	logic                      par_b3, par_b4, par_b5;
	logic signed [COORD_W-1:0] base_b3 [2], base_b4 [2];
	logic signed [PROD_W-1:0]  plo_b3  [2];
	logic signed [63:0]        phi_b3  [2];

	// Stage 4: full product; stage 5: clamped coordinate.
	logic signed [MUL_W-1:0]   prod_b4 [2];
	logic signed [COORD_W-1:0] crd_b5  [2];

	logic signed [MUL_W-1:0]   shf     [2];
	logic signed [SUM_W-1:0]   sum     [2];
	logic signed [COORD_W-1:0] sat     [2];
	logic [COORD_W-1:0]        cmag    [2];
	logic signed [COORD_W-1:0] snapped [2];

	// Parameter range and endpoint nearness.
	always_comb begin
		t1e = {{3{param_in.t1[T_W-1]}}, param_in.t1};
		t2e = {{3{param_in.t2[T_W-1]}}, param_in.t2};
		slk = $signed({{(FLG_W-24){1'b0}}, param_tol});
		one = $signed(FLG_W'(1) << TFRAC);
		on1_c  = (t1e >= -slk) && (t1e <= one + slk);
		on2_c  = (t2e >= -slk) && (t2e <= one + slk);
		near_c = ((t1e >= -slk) && (t1e <= slk))
			|| ((t1e >= one - slk) && (t1e <= one + slk));
	end

	// Rebuild each coordinate: base plus floor(dir * t / 2^TFRAC), clamped and snapped.
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			shf[c] = prod_b4[c] >>> TFRAC;
			sum[c] = {{(SUM_W-COORD_W){base_b4[c][COORD_W-1]}}, base_b4[c]}
				+ {shf[c][MUL_W-1], shf[c]};
			if (sum[c][SUM_W-1] && !(&sum[c][SUM_W-1:COORD_W-1])) begin
				sat[c] = {1'b1, {(COORD_W-1){1'b0}}};
			end else if (!sum[c][SUM_W-1] && (|sum[c][SUM_W-1:COORD_W-1])) begin
				sat[c] = {1'b0, {(COORD_W-1){1'b1}}};
			end else begin
				sat[c] = sum[c][COORD_W-1:0];
			end
			cmag[c]    = crd_b5[c][COORD_W-1] ? (~crd_b5[c] + 1'b1) : crd_b5[c];
			snapped[c] = (par_b5 || (cmag[c] < {{(COORD_W-16){1'b0}}, result_snap_tol}))
				? '0 : crd_b5[c];
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1  <= 1'b0;
			valid_b2  <= 1'b0;
			valid_b3  <= 1'b0;
			valid_b4  <= 1'b0;
			valid_b5  <= 1'b0;
			valid_out <= 1'b0;
		end else if (en) begin
			valid_b1  <= valid_in;
			valid_b2  <= valid_b1;
			valid_b3  <= valid_b2;
			valid_b4  <= valid_b3;
			valid_b5  <= valid_b4;
			valid_out <= valid_b5;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			on1_b1  <= on1_c;
			on2_b1  <= on2_c;
			near_b1 <= near_c;
			par_b1  <= param_in.par;
			t1_b1   <= param_in.t1;
			t2_b1   <= param_in.t2;
			side_b1 <= param_in.side;

			// Segment two is used when t1 sits near an endpoint.
			par_b2     <= par_b1;
			base_b2[0] <= near_b1 ? side_b1.b2_x : side_b1.b1_x;
			base_b2[1] <= near_b1 ? side_b1.b2_y : side_b1.b1_y;
			dir_b2[0]  <= near_b1 ? side_b1.dx2 : side_b1.dx1;
			dir_b2[1]  <= near_b1 ? side_b1.dy2 : side_b1.dy1;
			t_b2       <= near_b1 ? t2_b1 : t1_b1;
			if (par_b1) begin
				status_b2 <= ST_PARALLEL;
			end else if (on1_b1 && on2_b1) begin
				status_b2 <= ST_ON_BOTH;
			end else begin
				status_b2 <= ST_EXTENSION;
			end

			status_b3 <= status_b2;
			status_b4 <= status_b3;
			status_b5 <= status_b4;
			par_b3    <= par_b2;
			par_b4    <= par_b3;
			par_b5    <= par_b4;
			for (int c = 0; c < 2; c++) begin
				base_b3[c] <= base_b2[c];
				base_b4[c] <= base_b3[c];
				plo_b3[c]  <= $signed(dir_b2[c]) * $signed({1'b0, t_b2[31:0]});
				phi_b3[c]  <= $signed(dir_b2[c]) * $signed(t_b2[T_W-1:32]);
				prod_b4[c] <= $signed({phi_b3[c], 32'b0})
					+ $signed({{(MUL_W-PROD_W){plo_b3[c][PROD_W-1]}}, plo_b3[c]});
				crd_b5[c]  <= sat[c];
			end

			result_out.status  <= status_b5;
			result_out.cross_x <= snapped[0];
			result_out.cross_y <= snapped[1];
		end
	end

endmodule

// File: sv/segment_intersection_2d_core.sv
// An accepted input item passes the front end, the divider with its 62-stage
// quotient pipeline and the back end; its result is then offered from the output
// buffer. Throughput: one item per cycle while the two-entry output buffer is not
// full; it keeps the pipeline moving while a result waits. Reset (arst_n low) clears
// all valid bits and the output buffer and loads the config registers with defaults.
// ----------------------------------------------------------------------------
// Segment intersection core
// Pipelined 2-D segment intersection with configurable tolerances.
// ----------------------------------------------------------------------------
`include "segment_intersection_2d_core_defines.svh"

module segment_intersection_2d_core #(
	parameter int unsigned TFRAC = sic_pkg::TFRAC_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [sic_pkg::COORD_W-1:0]      b1_x,
	input  logic signed [sic_pkg::COORD_W-1:0]      b1_y,
	input  logic signed [sic_pkg::COORD_W-1:0]      e1_x,
	input  logic signed [sic_pkg::COORD_W-1:0]      e1_y,
	input  logic signed [sic_pkg::COORD_W-1:0]      b2_x,
	input  logic signed [sic_pkg::COORD_W-1:0]      b2_y,
	input  logic signed [sic_pkg::COORD_W-1:0]      e2_x,
	input  logic signed [sic_pkg::COORD_W-1:0]      e2_y,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [sic_pkg::STATUS_W-1:0]            status,
	output logic signed [sic_pkg::COORD_W-1:0]      cross_x,
	output logic signed [sic_pkg::COORD_W-1:0]      cross_y,
	input  logic                                    cfg_we,
	input  logic [sic_pkg::CFG_IDX_W-1:0]           cfg_idx,
	input  logic [sic_pkg::CFG_W-1:0]               cfg_wdata
);
	import sic_pkg::*;

	logic [15:0] axis_snap_tol_q;
	logic [31:0] det_tol_q;
	logic [23:0] param_tol_q;
	logic [15:0] result_snap_tol_q;

	logic    en;
	logic    valid_f, valid_d, valid_r;
	front_t  front_f;
	param_t  param_d;
	result_t result_r;

	logic [1:0] cnt_q;
	result_t    slot0_q, slot1_q;
	logic       push, pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_snap_tol_q   <= AXIS_SNAP_RST;
			det_tol_q         <= DET_TOL_RST;
			param_tol_q       <= PARAM_TOL_RST;
			result_snap_tol_q <= RESULT_SNAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_AXIS_SNAP:   axis_snap_tol_q   <= cfg_wdata[15:0];
				REG_DET_TOL:     det_tol_q         <= cfg_wdata[31:0];
				REG_PARAM_TOL:   param_tol_q       <= cfg_wdata[23:0];
				REG_RESULT_SNAP: result_snap_tol_q <= cfg_wdata[15:0];
			endcase
		end
	end

	// The whole pipeline advances unless the output buffer is full.
	assign en       = (cnt_q != 2'd2);
	assign in_ready = en;

	sic_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.valid_in      (in_valid),
		.b1_x          (b1_x),
		.b1_y          (b1_y),
		.e1_x          (e1_x),
		.e1_y          (e1_y),
		.b2_x          (b2_x),
		.b2_y          (b2_y),
		.e2_x          (e2_x),
		.e2_y          (e2_y),
		.axis_snap_tol (axis_snap_tol_q),
		.valid_s3      (valid_f),
		.front_s3      (front_f)
	);

	sic_div #(
		.TFRAC (TFRAC)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (valid_f),
		.front_in  (front_f),
		.det_tol   (det_tol_q),
		.valid_out (valid_d),
		.param_out (param_d)
	);

	sic_back #(
		.TFRAC (TFRAC)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.valid_in        (valid_d),
		.param_in        (param_d),
		.param_tol       (param_tol_q),
		.result_snap_tol (result_snap_tol_q),
		.valid_out       (valid_r),
		.result_out      (result_r)
	);

	// Two-entry output buffer; slot0 is the head.
	assign push = en && valid_r;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			slot0_q <= (push && (cnt_q == 2'd1)) ? result_r : slot1_q;
			if (push && (cnt_q == 2'd2)) begin
				slot1_q <= result_r;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				slot0_q <= result_r;
			end else begin
				slot1_q <= result_r;
			end
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign status    = slot0_q.status;
	assign cross_x   = slot0_q.cross_x;
	assign cross_y   = slot0_q.cross_y;

	// Checks.
	`SIC_ASSERT_NOW(a_buf_bound, clk, arst_n, 1'b1, cnt_q != 2'd3, "output buffer overflow")
	`SIC_ASSERT_NEXT(a_buf_count, clk, arst_n, 1'b1, cnt_q == $past(cnt_q) + {1'b0, $past(push)} - {1'b0, $past(pop)}, "output buffer count mismatch")
	`SIC_ASSERT_NOW(a_par_zero, clk, arst_n, out_valid && (status == ST_PARALLEL), (cross_x == '0) && (cross_y == '0), "parallel result with nonzero crossing")

endmodule

// File: tb/segment_intersection_2d_checker.sv
// ----------------------------------------------------------------------------
// Segment intersection checker
// Watches the input, result and register ports of the core. It predicts each
// result from the accepted segment pair and compares it field by field.
// ----------------------------------------------------------------------------
module segment_intersection_2d_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [sic_pkg::COORD_W-1:0]  b1_x,
	input  logic signed [sic_pkg::COORD_W-1:0]  b1_y,
	input  logic signed [sic_pkg::COORD_W-1:0]  e1_x,
	input  logic signed [sic_pkg::COORD_W-1:0]  e1_y,
	input  logic signed [sic_pkg::COORD_W-1:0]  b2_x,
	input  logic signed [sic_pkg::COORD_W-1:0]  b2_y,
	input  logic signed [sic_pkg::COORD_W-1:0]  e2_x,
	input  logic signed [sic_pkg::COORD_W-1:0]  e2_y,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [sic_pkg::STATUS_W-1:0]        status,
	input  logic signed [sic_pkg::COORD_W-1:0]  cross_x,
	input  logic signed [sic_pkg::COORD_W-1:0]  cross_y,
	input  logic                                cfg_we,
	input  logic [sic_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [sic_pkg::CFG_W-1:0]           cfg_wdata,
	output int                                  errors,
	output int                                  pending
);

	timeunit 1ns;
	timeprecision 1ps;

	import sic_pkg::*;

	typedef logic signed [127:0] wide_t;

	localparam int    TF    = TFRAC_DEF;
	localparam wide_t T_MAX = (wide_t'(1) <<< 62) - 1;
	localparam wide_t C_MAX = (wide_t'(1) <<< 31) - 1;
	localparam wide_t C_MIN = -(wide_t'(1) <<< 31);

	logic [15:0] axis_tol;
	logic [31:0] det_tol;
	logic [23:0] par_tol;
	logic [15:0] res_tol;

	result_t crossings_due[$];

	function automatic wide_t mag(wide_t v);
		return v < 0 ? -v : v;
	endfunction

	// Tiny direction components are treated as zero.
	function automatic wide_t snap_dir(wide_t d);
		return mag(d) < $signed({112'b0, axis_tol}) ? wide_t'(0) : d;
	endfunction

	// Segment parameter: truncated magnitude quotient, saturated, sign applied last.
	function automatic wide_t seg_param(wide_t num, wide_t den);
		logic [127:0] q;
		q = (128'(mag(num)) << TF) / 128'(mag(den));
		if (q > 128'(T_MAX))
			q = 128'(T_MAX);
		return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
	endfunction

	// Crossing coordinate rebuilt from one segment, saturated and snapped.
	function automatic logic signed [COORD_W-1:0] rebuild(wide_t base, wide_t dir, wide_t t);
		wide_t v;
		v = base + ((dir * t) >>> TF);
		if (v > C_MAX)
			v = C_MAX;
		else if (v < C_MIN)
			v = C_MIN;
		if (mag(v) < $signed({112'b0, res_tol}))
			v = 0;
		return v[COORD_W-1:0];
	endfunction

	function automatic result_t predict_crossing(wide_t p1x, wide_t p1y, wide_t q1x, wide_t q1y,
			wide_t p2x, wide_t p2y, wide_t q2x, wide_t q2y);
		result_t r;
		wide_t   dx1, dy1, dx2, dy2, wx, wy, det, t1, t2, one, slack;
		logic    on1, on2;
		dx1 = snap_dir(q1x - p1x);
		dy1 = snap_dir(q1y - p1y);
		dx2 = snap_dir(q2x - p2x);
		dy2 = snap_dir(q2y - p2y);
		wx = p1x - p2x;
		wy = p1y - p2y;
		det = dx2 * dy1 - dy2 * dx1;
		r = '0;
		r.status = ST_PARALLEL;
		if (mag(det) <= $signed({96'b0, det_tol}))
			return r;
		t1 = seg_param(dy2 * wx - dx2 * wy, det);
		t2 = seg_param(dy1 * wx - dx1 * wy, det);
		one = wide_t'(1) <<< TF;
		slack = $signed({104'b0, par_tol});
		on1 = t1 >= -slack && t1 <= one + slack;
		on2 = t2 >= -slack && t2 <= one + slack;
		r.status = (on1 && on2) ? ST_ON_BOTH : ST_EXTENSION;
		// Near either end of segment one the crossing comes from segment two.
		if (mag(t1 - one) > slack && mag(t1) > slack) begin
			r.cross_x = rebuild(p1x, dx1, t1);
			r.cross_y = rebuild(p1y, dy1, t1);
		end else begin
			r.cross_x = rebuild(p2x, dx2, t2);
			r.cross_y = rebuild(p2y, dy2, t2);
		end
		return r;
	endfunction

	assign pending = crossings_due.size();

	// Register shadow, input prediction and result comparison.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			axis_tol <= AXIS_SNAP_RST;
			det_tol  <= DET_TOL_RST;
			par_tol  <= PARAM_TOL_RST;
			res_tol  <= RESULT_SNAP_RST;
			crossings_due.delete();
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_AXIS_SNAP: axis_tol <= cfg_wdata[15:0];
					REG_DET_TOL: det_tol <= cfg_wdata;
					REG_PARAM_TOL: par_tol <= cfg_wdata[23:0];
					REG_RESULT_SNAP: res_tol <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				crossings_due.push_back(predict_crossing(b1_x, b1_y, e1_x, e1_y,
					b2_x, b2_y, e2_x, e2_y));
			if (out_valid && out_ready) begin
				if (crossings_due.size() == 0) begin
					if (errors < 10)
						$display("ERROR: result item with none expected: %0d %0d %0d",
							status, cross_x, cross_y);
					errors <= errors + 1;
				end else begin
					want = crossings_due.pop_front();
					if (want.status !== status || want.cross_x !== cross_x
							|| want.cross_y !== cross_y) begin
						if (errors < 10)
							$display("ERROR: expected status %0d x %0d y %0d, got %0d %0d %0d",
								want.status, want.cross_x, want.cross_y,
								status, cross_x, cross_y);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// File: tb/tb_segment_intersection_2d_core.sv
// ----------------------------------------------------------------------------
// Segment intersection core testbench
// Drives directed and random segment pairs under several tolerance settings,
// with random idling on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_segment_intersection_2d_core;

	timeunit 1ns;
	timeprecision 1ps;

	import sic_pkg::*;

	localparam int    CYCLE_LIMIT = 400000;
	localparam int    ONE         = 65536;
	localparam int    DRAIN       = 100;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [COORD_W-1:0] b1_x, b1_y, e1_x, e1_y, b2_x, b2_y, e2_x, e2_y;
	logic [STATUS_W-1:0]       status;
	logic signed [COORD_W-1:0] cross_x, cross_y;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_idx;
	logic [CFG_W-1:0]          cfg_wdata;
	int                        errors, pending;
	int                        cycles = 0;
	logic                      calm = 1'b0;
	logic                      hold_req = 1'b0;

	segment_intersection_2d_core DUT (.*);

	segment_intersection_2d_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				out_ready <= 1'b1;
			end else if (calm || $urandom_range(0, 5) != 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14) - 1) @(posedge clk);
			end
		end
	end

	// Offer one segment pair and hold it until accepted.
	task automatic send_pair(int p1x, int p1y, int q1x, int q1y,
			int p2x, int p2y, int q2x, int q2y);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		b1_x <= p1x; b1_y <= p1y; e1_x <= q1x; e1_y <= q1y;
		b2_x <= p2x; b2_y <= p2y; e2_x <= q2x; e2_y <= q2y;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
	endtask

	// Lower valid and wait until every result is back.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_tols(logic [15:0] a, logic [31:0] d, logic [23:0] p, logic [15:0] r);
		write_reg(REG_AXIS_SNAP, {16'b0, a});
		write_reg(REG_DET_TOL, d);
		write_reg(REG_PARAM_TOL, {8'b0, p});
		write_reg(REG_RESULT_SNAP, {16'b0, r});
	endtask

	// Random pair: mostly crossing-style geometry at modest scale, some raw noise.
	task automatic send_random;
		int c[8];
		int kind, sc, k;
		kind = $urandom_range(0, 9);
		sc = $urandom_range(4, 30);
		for (k = 0; k < 8; k++) begin
			if (kind == 0)
				c[k] = $urandom;
			else
				c[k] = $signed($urandom_range(0, (1 << sc) - 1)) - (1 << (sc - 1));
		end
		if (kind == 1) begin
			// Parallel: segment two is segment one shifted.
			c[4] = c[0] + sc; c[5] = c[1] - sc;
			c[6] = c[2] + sc; c[7] = c[3] - sc;
		end else if (kind == 2) begin
			// Shared endpoint.
			c[4] = c[$urandom_range(0, 1) * 2];
			c[5] = c[4] == c[0] ? c[1] : c[3];
		end else if (kind == 3) begin
			// Nearly axis-aligned direction.
			c[2] = c[0] + $signed($urandom_range(0, 16)) - 8;
		end
		send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
	endtask

	task automatic random_run(int n);
		repeat (n) send_random();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_AXIS_SNAP;
		cfg_wdata <= '0;
		{b1_x, b1_y, e1_x, e1_y, b2_x, b2_y, e2_x, e2_y} <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs at reset tolerances.
		send_pair(0, 0, 0, 0, 0, 0, 0, 0);
		send_pair(0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0);
		send_pair(0, 0, ONE, 0, 3*ONE, -ONE, 3*ONE, ONE);
		send_pair(0, 0, ONE, ONE, 5*ONE, 0, 6*ONE, ONE);
		send_pair(0, 0, 4*ONE, 0, 0, -ONE, 0, ONE);
		send_pair(0, 0, 4*ONE, 0, 4*ONE, -ONE, 4*ONE, ONE);
		send_pair(0, 0, 4*ONE, 0, ONE, 0, ONE, ONE);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_pair(0, 0, ONE, 1, 32'h7fff_ffff, 0, 32'h7fff_ffff, ONE);
		send_pair(0, 0, 1, ONE, 0, 32'h7fff_ffff, 100000, 32'h7fff_fff0);
		send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_fff0, 32'h7fff_fff0,
			32'h8000_0000, 0, 32'h8000_0010, 10);
		send_pair(0, 0, 3, ONE, -ONE, ONE/2, ONE, ONE/2);
		send_pair(1, 1, ONE+1, ONE+1, 1, ONE+1, ONE+1, 1);
		send_pair(0, 0, 300, 300, 0, 300, 300, 0);
		send_pair(-ONE, -ONE, ONE, ONE, -ONE, ONE, ONE, -ONE);
		send_pair(0, 0, ONE, 0, 0, 0, 0, ONE);
		drain();

		// Extremes: every tolerance off.
		set_tols(16'd0, 32'd0, 24'd0, 16'd0);
		send_pair(0, 0, 2, 1, 0, 1, 1, 0);
		send_pair(0, 0, ONE, 0, 0, 0, 0, ONE);
		random_run(80);
		drain();

		// Extremes: every tolerance at its maximum.
		set_tols(16'hffff, 32'hffff_ffff, 24'hff_ffff, 16'hffff);
		random_run(60);
		drain();

		// Long receiver hold-off while items keep coming.
		set_tols(16'd7, 32'd42950, 24'd168, 16'd1);
		hold_req = 1'b1;
		random_run(150);
		drain();

		// Mid-range random tolerances.
		set_tols($urandom_range(0, 64), $urandom_range(0, 1 << 20),
			$urandom_range(0, 1 << 16), $urandom_range(0, 300));
		random_run(120);
		drain();

		// Reset tolerances again, final stretch without idling.
		set_tols(AXIS_SNAP_RST, DET_TOL_RST, PARAM_TOL_RST, RESULT_SNAP_RST);
		calm = 1'b1;
		random_run(100);
		drain();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
